// ===== design/dcds_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcds_pkg: shared types and digit arithmetic
// Widths, counts and the mod-10 digit helpers used by the digit scramble.
// ----------------------------------------------------------------------------
package dcds_pkg;

  localparam int MAX_DIGITS  = 8;
  localparam int VAL_W       = 27;
  localparam int KEY_W       = 30;
  localparam int BIN_W       = 30;   // widest binary operand to convert
  localparam int BCD_DIGITS  = 10;   // enough decimal digits for BIN_W bits
  localparam int CNT_W       = $clog2(BIN_W + 1);
  localparam int LEAD_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int DCNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int ROUND_LIMIT = 400;
  localparam int ROUND_W     = $clog2(ROUND_LIMIT + 1);

  localparam logic [KEY_W-1:0] KEY_RESET = KEY_W'(9371);

  typedef logic [3:0] digit_t;
  typedef digit_t [BCD_DIGITS-1:0] bcd_t;
  typedef digit_t [MAX_DIGITS-1:0] dvec_t;

  typedef struct packed {
    logic              load;
    logic [LEAD_W-1:0] lead;
  } conv_req_t;

  typedef struct packed {
    logic done;
    logic fail;
  } conv_rsp_t;

  // one double-dabble step: adjust every digit, then shift in a new bit
  function automatic bcd_t dd_step(bcd_t b, logic bit_in);
    bcd_t                    adj;
    logic [4*BCD_DIGITS-1:0] flat;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[i] = (b[i] >= 4'd5) ? b[i] + 4'd3 : b[i];
    end
    flat = adj;
    return {flat[4*BCD_DIGITS-2:0], bit_in};
  endfunction

  // (a * b) mod 10 for decimal digits, via reciprocal multiply
  function automatic digit_t mul_mod10(digit_t a, digit_t b);
    logic [7:0]  p;
    logic [15:0] t;
    logic [3:0]  q;
    logic [7:0]  r;
    p = {4'd0, a} * {4'd0, b};
    t = {8'd0, p} * 16'd205;
    q = t[14:11];
    r = p - {1'b0, q, 3'b000} - {3'b000, q, 1'b0};
    return r[3:0];
  endfunction

  // (a + b) mod 10 for decimal digits
  function automatic digit_t add_mod10(digit_t a, digit_t b);
    logic [4:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[3:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/decimal_carryless_digit_scramble.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_carryless_digit_scramble: decimal digit scramble with cycle walk
// Splits the number and key into decimal digits, forms the carry-less digit
// convolution mod 10 over the number's own digit count, and repeats it while
// the leading digit comes out zero.
// ----------------------------------------------------------------------------
//
//  Port group  Handshake                 Payload
//  in          in_valid / in_stall       in_value (27 b)
//  out         out_valid / out_stall     out_code (27 b), out_invalid
//  cfg         cfg_valid / cfg_ready     cfg_key (30 b)
//
//  Flow: one request at a time; a valid number's result is registered after
//  conversion to digits, up to 400 walk rounds, conversion back and a
//  handoff, a zero or too-long one after conversion to digits alone; the
//  next request can be taken in the cycle after the result is registered.
//  Reset: the key returns to 9371; no memory, no clearing pass.
//  Stalls: a finished result waits in its last state for a free output slot.
//
module decimal_carryless_digit_scramble (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dcds_pkg::VAL_W-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dcds_pkg::VAL_W-1:0] out_code,
  output logic                       out_invalid,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dcds_pkg::KEY_W-1:0] cfg_key
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_B2D  = 5'b00010,
    ST_CONV = 5'b00100,
    ST_D2B  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [dcds_pkg::KEY_W-1:0]  key_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [dcds_pkg::VAL_W-1:0]  out_code_r, out_code_nxt;
  logic                        out_invalid_r, out_invalid_nxt;
  logic [dcds_pkg::VAL_W-1:0]  res_code_r, res_code_nxt;
  logic                        res_inv_r, res_inv_nxt;

  logic                        in_take;
  logic                        b2d_done;
  dcds_pkg::bcd_t              val_bcd;
  dcds_pkg::bcd_t              key_bcd;
  dcds_pkg::dvec_t             v_dig;
  dcds_pkg::dvec_t             k_dig;
  logic [dcds_pkg::LEAD_W-1:0] lead;
  logic                        any_low;
  logic                        too_many;
  dcds_pkg::conv_req_t         conv_req;
  dcds_pkg::conv_rsp_t         conv_rsp;
  dcds_pkg::dvec_t             conv_res;
  logic                        d2b_load;
  logic                        d2b_done;
  logic [dcds_pkg::VAL_W-1:0]  d2b_bin;

  // one request in flight: stall the input outside the idle state
  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // key register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= dcds_pkg::KEY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      key_r <= cfg_key;
    end
  end

  dcds_b2d u_b2d (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (in_take),
    .value   (in_value),
    .key     (key_r),
    .done    (b2d_done),
    .val_bcd (val_bcd),
    .key_bcd (key_bcd)
  );

  // digit count: leading nonzero digit among the low lanes; anything above
  // the lane count, or no digit at all, makes the request invalid
  always_comb begin
    lead     = '0;
    any_low  = 1'b0;
    too_many = 1'b0;
    for (int i = 0; i < dcds_pkg::MAX_DIGITS; i++) begin
      v_dig[i] = val_bcd[i];
      k_dig[i] = key_bcd[i];
      if (val_bcd[i] != 4'd0) begin
        lead    = dcds_pkg::LEAD_W'(i);
        any_low = 1'b1;
      end
    end
    for (int i = dcds_pkg::MAX_DIGITS; i < dcds_pkg::BCD_DIGITS; i++) begin
      if (val_bcd[i] != 4'd0) begin
        too_many = 1'b1;
      end
    end
  end

  assign conv_req.load = (state_r == ST_B2D) && b2d_done && any_low && !too_many;
  assign conv_req.lead = lead;

  dcds_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (conv_req),
    .v_in  (v_dig),
    .k_in  (k_dig),
    .rsp   (conv_rsp),
    .res   (conv_res)
  );

  assign d2b_load = (state_r == ST_CONV) && conv_rsp.done && !conv_rsp.fail;

  dcds_d2b u_d2b (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (d2b_load),
    .digits (conv_res),
    .done   (d2b_done),
    .bin    (d2b_bin)
  );

  // sequencer and output register
  always_comb begin
    state_nxt       = state_r;
    res_code_nxt    = res_code_r;
    res_inv_nxt     = res_inv_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_code_nxt    = out_code_r;
    out_invalid_nxt = out_invalid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_B2D;
        end
      end
      ST_B2D: begin
        if (b2d_done) begin
          if (any_low && !too_many) begin
            state_nxt = ST_CONV;
          end else begin
            // zero or too many digits: no code
            res_code_nxt = '0;
            res_inv_nxt  = 1'b1;
            state_nxt    = ST_DONE;
          end
        end
      end
      ST_CONV: begin
        if (conv_rsp.done) begin
          if (conv_rsp.fail) begin
            // walk never reached a nonzero leading digit
            res_code_nxt = '0;
            res_inv_nxt  = 1'b1;
            state_nxt    = ST_DONE;
          end else begin
            state_nxt = ST_D2B;
          end
        end
      end
      ST_D2B: begin
        if (d2b_done) begin
          res_code_nxt = d2b_bin;
          res_inv_nxt  = 1'b0;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register frees up
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_code_nxt    = res_code_r;
          out_invalid_nxt = res_inv_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r    <= out_code_nxt;
    out_invalid_r <= out_invalid_nxt;
    res_code_r    <= res_code_nxt;
    res_inv_r     <= res_inv_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_code    = out_code_r;
  assign out_invalid = out_invalid_r;

`ifndef SYNTH
  a_take_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("input not stalled after a request was taken");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_invalid) |-> (out_code == '0))
    else $error("invalid result carries a nonzero code");

  a_b2d_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    b2d_done |-> (state_r == ST_B2D))
    else $error("conversion finished outside its state");

  a_conv_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    conv_rsp.done |-> (state_r == ST_CONV))
    else $error("scramble round finished outside its state");
`endif

endmodule
`default_nettype wire

// ===== design/dcds_b2d.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcds_b2d: bit-serial binary to decimal converter
// Converts value and key side by side, one bit per cycle (double dabble).
// ----------------------------------------------------------------------------
module dcds_b2d (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic [dcds_pkg::VAL_W-1:0] value,
  input  logic [dcds_pkg::KEY_W-1:0] key,
  output logic                      done,
  output dcds_pkg::bcd_t            val_bcd,
  output dcds_pkg::bcd_t            key_bcd
);

  logic [dcds_pkg::BIN_W-1:0] val_bin_r, val_bin_nxt;
  logic [dcds_pkg::BIN_W-1:0] key_bin_r, key_bin_nxt;
  dcds_pkg::bcd_t             val_bcd_r, val_bcd_nxt;
  dcds_pkg::bcd_t             key_bcd_r, key_bcd_nxt;
  logic [dcds_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;

  always_comb begin
    busy_nxt    = busy_r;
    cnt_nxt     = cnt_r;
    done_nxt    = 1'b0;
    val_bin_nxt = val_bin_r;
    key_bin_nxt = key_bin_r;
    val_bcd_nxt = val_bcd_r;
    key_bcd_nxt = key_bcd_r;
    if (load) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = dcds_pkg::CNT_W'(dcds_pkg::BIN_W);
      val_bin_nxt = dcds_pkg::BIN_W'(value);
      key_bin_nxt = dcds_pkg::BIN_W'(key);
      val_bcd_nxt = '0;
      key_bcd_nxt = '0;
    end else if (busy_r) begin
      val_bcd_nxt = dcds_pkg::dd_step(val_bcd_r, val_bin_r[dcds_pkg::BIN_W-1]);
      key_bcd_nxt = dcds_pkg::dd_step(key_bcd_r, key_bin_r[dcds_pkg::BIN_W-1]);
      val_bin_nxt = {val_bin_r[dcds_pkg::BIN_W-2:0], 1'b0};
      key_bin_nxt = {key_bin_r[dcds_pkg::BIN_W-2:0], 1'b0};
      cnt_nxt     = cnt_r - 1'b1;
      if (cnt_r == dcds_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_bin_r <= val_bin_nxt;
    key_bin_r <= key_bin_nxt;
    val_bcd_r <= val_bcd_nxt;
    key_bcd_r <= key_bcd_nxt;
  end

  assign done    = done_r;
  assign val_bcd = val_bcd_r;
  assign key_bcd = key_bcd_r;

endmodule
`default_nettype wire

// ===== design/dcds_conv.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcds_conv: digit-serial carry-less convolution with cycle walking
// Feeds one value digit per cycle into all result lanes; repeats rounds
// until the leading digit is nonzero or the round limit runs out.
// ----------------------------------------------------------------------------
module dcds_conv (
  input  logic                clk,
  input  logic                rst_n,
  input  dcds_pkg::conv_req_t req,
  input  dcds_pkg::dvec_t     v_in,
  input  dcds_pkg::dvec_t     k_in,
  output dcds_pkg::conv_rsp_t rsp,
  output dcds_pkg::dvec_t     res
);

  typedef enum logic [2:0] {
    CV_IDLE  = 3'b001,
    CV_RUN   = 3'b010,
    CV_CHECK = 3'b100
  } cv_state_t;

  cv_state_t                     state_r, state_nxt;
  dcds_pkg::dvec_t               k_r, k_nxt;
  dcds_pkg::dvec_t               ks_r, ks_nxt;
  dcds_pkg::dvec_t               vs_r, vs_nxt;
  dcds_pkg::dvec_t               acc_r, acc_nxt;
  dcds_pkg::dvec_t               res_r, res_nxt;
  dcds_pkg::dvec_t               masked;
  logic [dcds_pkg::LEAD_W-1:0]   step_r, step_nxt;
  logic [dcds_pkg::LEAD_W-1:0]   lead_r, lead_nxt;
  logic [dcds_pkg::ROUND_W-1:0]  rounds_r, rounds_nxt;
  logic                          done_r, done_nxt;
  logic                          fail_r, fail_nxt;

  // drop lanes above the leading digit
  always_comb begin
    for (int i = 0; i < dcds_pkg::MAX_DIGITS; i++) begin
      masked[i] = (dcds_pkg::LEAD_W'(i) <= lead_r) ? acc_r[i] : 4'd0;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    ks_nxt     = ks_r;
    vs_nxt     = vs_r;
    acc_nxt    = acc_r;
    res_nxt    = res_r;
    step_nxt   = step_r;
    lead_nxt   = lead_r;
    rounds_nxt = rounds_r;
    done_nxt   = 1'b0;
    fail_nxt   = fail_r;
    unique case (state_r)
      CV_IDLE: begin
        if (req.load) begin
          k_nxt      = k_in;
          ks_nxt     = k_in;
          vs_nxt     = v_in;
          acc_nxt    = '0;
          step_nxt   = '0;
          rounds_nxt = '0;
          lead_nxt   = req.lead;
          state_nxt  = CV_RUN;
        end
      end
      CV_RUN: begin
        for (int i = 0; i < dcds_pkg::MAX_DIGITS; i++) begin
          acc_nxt[i] = dcds_pkg::add_mod10(acc_r[i],
                                           dcds_pkg::mul_mod10(vs_r[0], ks_r[i]));
        end
        ks_nxt   = ks_r << 4;
        vs_nxt   = vs_r >> 4;
        step_nxt = step_r + 1'b1;
        if (step_r == dcds_pkg::LEAD_W'(dcds_pkg::MAX_DIGITS - 1)) begin
          state_nxt = CV_CHECK;
        end
      end
      CV_CHECK: begin
        if (acc_r[lead_r] != 4'd0) begin
          res_nxt   = masked;
          fail_nxt  = 1'b0;
          done_nxt  = 1'b1;
          state_nxt = CV_IDLE;
        end else if (rounds_r == dcds_pkg::ROUND_W'(dcds_pkg::ROUND_LIMIT - 1)) begin
          res_nxt   = '0;
          fail_nxt  = 1'b1;
          done_nxt  = 1'b1;
          state_nxt = CV_IDLE;
        end else begin
          rounds_nxt = rounds_r + 1'b1;
          vs_nxt     = masked;
          ks_nxt     = k_r;
          acc_nxt    = '0;
          step_nxt   = '0;
          state_nxt  = CV_RUN;
        end
      end
      default: begin
        state_nxt = CV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= CV_IDLE;
      done_r   <= 1'b0;
      fail_r   <= 1'b0;
      step_r   <= '0;
      rounds_r <= '0;
    end else begin
      state_r  <= state_nxt;
      done_r   <= done_nxt;
      fail_r   <= fail_nxt;
      step_r   <= step_nxt;
      rounds_r <= rounds_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    ks_r   <= ks_nxt;
    vs_r   <= vs_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
    lead_r <= lead_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.fail = fail_r;
  assign res      = res_r;

endmodule
`default_nettype wire

// ===== design/dcds_d2b.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcds_d2b: digit-serial decimal to binary converter
// Folds in one decimal digit per cycle, most significant first.
// ----------------------------------------------------------------------------
module dcds_d2b (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  dcds_pkg::dvec_t            digits,
  output logic                       done,
  output logic [dcds_pkg::VAL_W-1:0] bin
);

  dcds_pkg::dvec_t             ds_r, ds_nxt;
  logic [dcds_pkg::VAL_W-1:0]  bin_r, bin_nxt;
  logic [dcds_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;

  always_comb begin
    ds_nxt   = ds_r;
    bin_nxt  = bin_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (load) begin
      ds_nxt   = digits;
      bin_nxt  = '0;
      cnt_nxt  = dcds_pkg::DCNT_W'(dcds_pkg::MAX_DIGITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // bin * 10 + top digit
      bin_nxt = dcds_pkg::VAL_W'({bin_r, 3'b000})
              + dcds_pkg::VAL_W'({bin_r, 1'b0})
              + dcds_pkg::VAL_W'(ds_r[dcds_pkg::MAX_DIGITS-1]);
      ds_nxt  = ds_r << 4;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == dcds_pkg::DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ds_r  <= ds_nxt;
    bin_r <= bin_nxt;
  end

  assign done = done_r;
  assign bin  = bin_r;

endmodule
`default_nettype wire

// ===== bench/decimal_carryless_digit_scramble_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_carryless_digit_scramble_tb: self-checking bench for the digit scramble
// Drives numbers through the request channel under random gaps and output
// stalls, reprograms the key between phases and compares every result with a
// typed-in value or a local digit-convolution predictor with the cycle walk.
// ----------------------------------------------------------------------------
module decimal_carryless_digit_scramble_tb;

  localparam int               VAL_W       = dcds_pkg::VAL_W;
  localparam int               KEY_W       = dcds_pkg::KEY_W;
  localparam int               MAX_DIGITS  = dcds_pkg::MAX_DIGITS;
  localparam int               ROUND_LIMIT = dcds_pkg::ROUND_LIMIT;
  localparam logic [KEY_W-1:0] KEY_RESET   = dcds_pkg::KEY_RESET;

  // one result as the block reports it
  typedef struct packed {
    logic [VAL_W-1:0] code;
    logic             invalid;
  } code_rsp_t;

  // one directed request: key to run it under, the number, and optionally the
  // result typed in by hand
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    bit               typed;
    logic [VAL_W-1:0] code;
    logic             invalid;
  } directed_row_t;

  localparam int N_DIRECTED = 23;
  localparam logic [KEY_W-1:0] KEY_ALL_ONES = {KEY_W{1'b1}};

  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // reset key 9371, low key digit 1
    '{KEY_RESET, 27'd0,         1'b1, 27'd0, 1'b1},  // zero has no digits
    '{KEY_RESET, 27'd1,         1'b1, 27'd1, 1'b0},  // one digit times unit digit 1
    '{KEY_RESET, 27'd9,         1'b1, 27'd9, 1'b0},
    '{KEY_RESET, 27'd10,        1'b0, 27'd0, 1'b0},
    '{KEY_RESET, 27'd31,        1'b0, 27'd0, 1'b0},  // leading digit zero, walk again
    '{KEY_RESET, 27'd99,        1'b0, 27'd0, 1'b0},
    '{KEY_RESET, 27'd12345,     1'b0, 27'd0, 1'b0},
    '{KEY_RESET, 27'd10000000,  1'b0, 27'd0, 1'b0},  // smallest eight-digit number
    '{KEY_RESET, 27'd99999999,  1'b0, 27'd0, 1'b0},  // largest eight-digit number
    '{KEY_RESET, 27'd100000000, 1'b1, 27'd0, 1'b1},  // nine digits: refused
    '{KEY_RESET, 27'd134217727, 1'b1, 27'd0, 1'b1},  // every input bit high
    '{KEY_RESET, 27'd76543210,  1'b0, 27'd0, 1'b0},
    // key of zero: every round gives zero, no walk ever settles
    '{30'd0,     27'd5,         1'b1, 27'd0, 1'b1},
    '{30'd0,     27'd0,         1'b1, 27'd0, 1'b1},
    '{30'd0,     27'd99999999,  1'b1, 27'd0, 1'b1},
    // key above its range, all thirty bits set
    '{KEY_ALL_ONES, 27'd1,        1'b0, 27'd0, 1'b0},
    '{KEY_ALL_ONES, 27'd99999999, 1'b0, 27'd0, 1'b0},
    '{KEY_ALL_ONES, 27'd12345678, 1'b0, 27'd0, 1'b0},
    // top of the key range, low digit 9
    '{30'd999999999, 27'd1,        1'b1, 27'd9, 1'b0},
    '{30'd999999999, 27'd55555555, 1'b0, 27'd0, 1'b0},
    // low key digit 5 is no unit: some walks end, some run out of rounds
    '{30'd5,     27'd1,         1'b0, 27'd0, 1'b0},
    '{30'd5,     27'd2,         1'b0, 27'd0, 1'b0},
    '{30'd5,     27'd37,        1'b0, 27'd0, 1'b0}
  };

  // random phases with fixed keys; four phases with random unit keys follow
  localparam int N_KEY_PHASES = 8;
  localparam logic [KEY_W-1:0] PHASE_KEYS [N_KEY_PHASES] = '{
    KEY_RESET, 30'd999999999, KEY_ALL_ONES, 30'd1,
    30'd0, 30'd12345, 30'd2468, 30'd70
  };
  localparam int PHASE_ITEMS [N_KEY_PHASES] = '{300, 150, 150, 150, 15, 40, 40, 30};
  localparam int N_UNIT_PHASES = 4;
  localparam int UNIT_PHASE_ITEMS = 150;
  localparam int unsigned UNIT_DIGITS [4] = '{1, 3, 7, 9};

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic [VAL_W-1:0] in_value    = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic [VAL_W-1:0] out_code;
  logic             out_invalid;
  logic             cfg_valid   = 1'b0;
  logic             cfg_ready;
  logic [KEY_W-1:0] cfg_key     = '0;

  // key the block holds now, tracked on every accepted write
  logic [KEY_W-1:0] key_now = KEY_RESET;
  code_rsp_t        expected_codes [$];
  int unsigned      mismatch_count = 0;

  int unsigned      stall_run  = 0;
  int unsigned      stall_pick;
  logic             stall_hold = 1'b0;

  decimal_carryless_digit_scramble i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_code    (out_code),
    .out_invalid (out_invalid),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_key     (cfg_key)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Carry-less decimal multiply over the number's own digit count, repeated
  // while the leading digit comes out zero. Zero, nine-digit numbers and walks
  // that run out of rounds give the invalid flag with a zero code.
  function automatic code_rsp_t scramble_digits(input logic [VAL_W-1:0] value,
                                                input logic [KEY_W-1:0] key_word);
    code_rsp_t       rsp;
    longint unsigned rest;
    longint unsigned span;
    longint unsigned acc;
    int              ndig;
    int unsigned     sum;
    int unsigned     vd [MAX_DIGITS];
    int unsigned     kd [MAX_DIGITS];
    int unsigned     cd [MAX_DIGITS];
    bit              settled;
    rsp.code    = '0;
    rsp.invalid = 1'b1;
    ndig = 0;
    span = 1;
    while (64'(value) >= span && ndig < 10) begin
      ndig++;
      span *= 10;
    end
    if (ndig == 0 || ndig > MAX_DIGITS) begin
      return rsp;
    end
    rest = 64'(value);
    for (int i = 0; i < ndig; i++) begin
      vd[i] = 32'(rest % 10);
      rest  = rest / 10;
    end
    rest = 64'(key_word);
    for (int i = 0; i < ndig; i++) begin
      kd[i] = 32'(rest % 10);
      rest  = rest / 10;
    end
    settled = 1'b0;
    for (int round = 0; round < ROUND_LIMIT && !settled; round++) begin
      for (int i = 0; i < ndig; i++) begin
        sum = 0;
        for (int j = 0; j <= i; j++) begin
          sum += vd[j] * kd[i-j];
        end
        cd[i] = sum % 10;
      end
      for (int i = 0; i < ndig; i++) begin
        vd[i] = cd[i];
      end
      settled = (vd[ndig-1] != 0);
    end
    if (!settled) begin
      return rsp;
    end
    acc = 0;
    for (int i = ndig - 1; i >= 0; i--) begin
      acc = acc * 10 + 64'(vd[i]);
    end
    rsp.code    = acc[VAL_W-1:0];
    rsp.invalid = 1'b0;
    return rsp;
  endfunction

  // Mostly well-formed numbers of one to eight digits, spread evenly over the
  // digit count; the rest are zero, nine-digit numbers and raw 27-bit words.
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned     sel;
    int unsigned     ndig;
    longint unsigned lo;
    sel = $urandom_range(99);
    if (sel < 3) begin
      return '0;
    end
    if (sel < 7) begin
      return VAL_W'($urandom_range(134217727, 100000000));
    end
    if (sel < 12) begin
      return VAL_W'($urandom);
    end
    ndig = $urandom_range(MAX_DIGITS, 1);
    lo   = 1;
    for (int i = 1; i < ndig; i++) begin
      lo *= 10;
    end
    return VAL_W'($urandom_range(int'(lo * 10 - 1), int'(lo)));
  endfunction

  // mostly back to back or short gaps, now and then a long pause
  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) begin
      return 0;
    end
    if (sel < 85) begin
      return $urandom_range(3, 1);
    end
    if (sel < 95) begin
      return $urandom_range(10, 4);
    end
    return $urandom_range(60, 20);
  endfunction

  // Present one request at the falling edge and hold it until it is taken.
  // Log the expected result at the accepting edge, then idle for a random gap;
  // with no gap, leave valid high for the next request.
  task automatic send_value(input logic [VAL_W-1:0] value, input bit typed,
                            input code_rsp_t typed_rsp);
    int unsigned gap;
    @(negedge clk);
    in_value <= value;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (typed) begin
      expected_codes.push_back(typed_rsp);
    end else begin
      expected_codes.push_back(scramble_digits(value, key_now));
    end
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drop any request still on offer and wait for every result to come out
  task automatic drain_requests();
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    while (expected_codes.size() != 0) @(posedge clk);
  endtask

  // Reprogram the key only once the block is idle; the predictor follows the
  // key at the edge where the write is taken.
  task automatic write_key(input logic [KEY_W-1:0] key_word);
    drain_requests();
    @(negedge clk);
    cfg_key   <= key_word;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    key_now = key_word;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output stall: random runs of flow and stall, mostly short, with some
  // long free-flowing stretches and a few long stalls.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_pick = $urandom_range(99);
      if (stall_pick < 55) begin
        stall_hold = 1'b0;
        stall_run  = $urandom_range(8, 1);
      end else if (stall_pick < 80) begin
        stall_hold = 1'b1;
        stall_run  = $urandom_range(3, 1);
      end else if (stall_pick < 93) begin
        stall_hold = 1'b0;
        stall_run  = $urandom_range(200, 50);
      end else begin
        stall_hold = 1'b1;
        stall_run  = $urandom_range(40, 10);
      end
    end
    stall_run--;
    out_stall <= stall_hold;
  end

  // Compare every accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin : check_results
    code_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_codes.size() == 0) begin
        $error("unexpected result: code %0d, invalid %0b", out_code, out_invalid);
        mismatch_count++;
      end else begin
        want = expected_codes.pop_front();
        if (out_code !== want.code) begin
          $error("code: expected %0d, got %0d", want.code, out_code);
          mismatch_count++;
        end
        if (out_invalid !== want.invalid) begin
          $error("invalid: expected %0b, got %0b", want.invalid, out_invalid);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    code_rsp_t     typed_rsp;
    code_rsp_t     no_rsp;
    directed_row_t row;
    no_rsp = '0;

    // hold reset low, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows; change the key when a row asks for a different one
    for (int r = 0; r < N_DIRECTED; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.key != key_now) begin
        write_key(row.key);
      end
      typed_rsp.code    = row.code;
      typed_rsp.invalid = row.invalid;
      send_value(row.value, row.typed, typed_rsp);
    end

    // random numbers under fixed keys: extremes, identity, non-unit low digits
    for (int p = 0; p < N_KEY_PHASES; p++) begin
      write_key(PHASE_KEYS[p]);
      repeat (PHASE_ITEMS[p]) send_value(pick_value(), 1'b0, no_rsp);
    end

    // random keys whose low digit is a unit, so every walk ends
    for (int p = 0; p < N_UNIT_PHASES; p++) begin
      write_key(KEY_W'($urandom_range(99999999) * 10 + UNIT_DIGITS[$urandom_range(3)]));
      repeat (UNIT_PHASE_ITEMS) send_value(pick_value(), 1'b0, no_rsp);
    end

    // let the last results out, then allow for a straggler
    drain_requests();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hang; sized for every request walking all its rounds
  // behind the longest stalls and gaps.
  initial begin : watchdog
    #80_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dcds_pkg.sv
design/dcds_b2d.sv
design/dcds_conv.sv
design/dcds_d2b.sv
design/decimal_carryless_digit_scramble.sv
bench/decimal_carryless_digit_scramble_tb.sv
